### hw/rtl/qew_pkg.sv
// Shared widths, the arctangent step table and the pipeline side-band type
// for the quaternion to Euler and world acceleration datapath.
// No dependencies.
package qew_pkg;

  localparam int QW     = 32;
  localparam int AW     = 16;
  localparam int SLOT_W = 4;
  localparam int TW     = 35;
  localparam int MW     = 37;
  localparam int PW     = 53;
  localparam int SW     = 56;
  localparam int CLW    = 50;
  localparam int SQ_NW  = 61;
  localparam int SQ_W   = 62;
  localparam int SQ_RW  = 31;
  localparam int SQ_STEPS = 31;
  localparam int CXW    = 40;
  localparam int CZW    = 26;
  localparam int ROLL_W = 17;
  localparam int PITCH_W = 16;
  localparam int WACC_W = 17;

  localparam int CH_ROLL  = 0;
  localparam int CH_PITCH = 1;
  localparam int CH_YAW   = 2;

  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic signed [MW-1:0]      roll_x;
    logic signed [MW-1:0]      roll_y;
    logic signed [MW-1:0]      yaw_x;
    logic signed [MW-1:0]      yaw_y;
    logic signed [QW-1:0]      pitch_s;
    logic signed [AW-1:0]      body_x;
    logic signed [AW-1:0]      body_y;
    logic signed [AW-1:0]      body_z;
    logic signed [WACC_W-1:0]  world_x;
    logic signed [WACC_W-1:0]  world_y;
    logic signed [WACC_W-1:0]  world_z;
  } side_t;

  // Arctangent of 2^-i in degrees scaled by 65536.
  function automatic logic signed [CZW-1:0] atan_deg(input int unsigned i);
    logic signed [CZW-1:0] a;
    unique case (i)
      0:  a = 26'sd2949120;
      1:  a = 26'sd1740967;
      2:  a = 26'sd919879;
      3:  a = 26'sd466945;
      4:  a = 26'sd234379;
      5:  a = 26'sd117304;
      6:  a = 26'sd58666;
      7:  a = 26'sd29335;
      8:  a = 26'sd14668;
      9:  a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      16: a = 26'sd57;
      17: a = 26'sd29;
      18: a = 26'sd14;
      19: a = 26'sd7;
      20: a = 26'sd4;
      21: a = 26'sd2;
      22: a = 26'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Doubled quaternion product in Q30.
  function automatic logic signed [TW-1:0] dprod(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return p[2*QW-1:2*QW-TW];
  endfunction

endpackage

### hw/rtl/qew_if.sv
// Valid/ready channel interfaces for the input sample and the result beat.
// No dependencies.
interface qew_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         sample_slot;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [15:0] acc_raw_x;
  logic signed [15:0] acc_raw_y;
  logic signed [15:0] acc_raw_z;
  modport source(output valid, sample_slot, quat_w, quat_x, quat_y, quat_z,
                 acc_raw_x, acc_raw_y, acc_raw_z, input ready);
  modport sink(input valid, sample_slot, quat_w, quat_x, quat_y, quat_z,
               acc_raw_x, acc_raw_y, acc_raw_z, output ready);
endinterface

interface qew_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         slot_out;
  logic signed [16:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [16:0] yaw_angle;
  logic signed [15:0] body_acc_x;
  logic signed [15:0] body_acc_y;
  logic signed [15:0] body_acc_z;
  logic signed [16:0] world_acc_x;
  logic signed [16:0] world_acc_y;
  logic signed [16:0] world_acc_z;
  modport source(output valid, slot_out, roll_angle, pitch_angle, yaw_angle,
                 body_acc_x, body_acc_y, body_acc_z, world_acc_x, world_acc_y,
                 world_acc_z, input ready);
  modport sink(input valid, slot_out, roll_angle, pitch_angle, yaw_angle,
               body_acc_x, body_acc_y, body_acc_z, world_acc_x, world_acc_y,
               world_acc_z, output ready);
endinterface

### hw/rtl/qew_front.sv
// Five-stage front end: quaternion products, rotation matrix, body and world
// acceleration, and the radicand for the pitch cosine. Uses qew_pkg.
module qew_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [qew_pkg::SLOT_W-1:0]     in_slot,
  input  logic signed [qew_pkg::QW-1:0]  in_qw,
  input  logic signed [qew_pkg::QW-1:0]  in_qx,
  input  logic signed [qew_pkg::QW-1:0]  in_qy,
  input  logic signed [qew_pkg::QW-1:0]  in_qz,
  input  logic signed [qew_pkg::AW-1:0]  in_ax,
  input  logic signed [qew_pkg::AW-1:0]  in_ay,
  input  logic signed [qew_pkg::AW-1:0]  in_az,
  input  logic [qew_pkg::AW-1:0]         gravity,
  output logic                           out_valid,
  output qew_pkg::side_t                 out_side,
  output logic [qew_pkg::SQ_NW-1:0]      out_n
);
  import qew_pkg::*;

  localparam logic signed [MW-1:0]  Q_ONE_M = MW'(64'sd1073741824);
  localparam logic signed [SW-1:0]  W_LIM   = SW'(64'sd281474976710656);

  function automatic logic signed [WACC_W-1:0] wscale(input logic signed [CLW-1:0] s);
    logic signed [63:0] e;
    logic signed [63:0] m;
    logic signed [63:0] q;
    logic signed [WACC_W-1:0] r;
    e = 64'(s);
    m = (e <<< 13) + (e <<< 10) + (e <<< 9) + (e <<< 6) + (e <<< 3) + (64'sd1 <<< 43);
    q = m >>> 44;
    if (q > 64'sd65535) begin
      r = WACC_W'(65535);
    end else if (q < -64'sd65535) begin
      r = -WACC_W'(65535);
    end else begin
      r = q[WACC_W-1:0];
    end
    return r;
  endfunction

  // Stage A
  logic                   va_r;
  logic [SLOT_W-1:0]      slot_a_r;
  logic signed [AW-1:0]   acc_a_r [3];
  logic signed [TW-1:0]   t11_r, t22_r, t33_r, t01_r, t02_r, t03_r, t12_r, t13_r, t23_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot_a_r   <= in_slot;
      acc_a_r[0] <= in_ax;
      acc_a_r[1] <= in_ay;
      acc_a_r[2] <= in_az;
      t11_r <= dprod(in_qx, in_qx);
      t22_r <= dprod(in_qy, in_qy);
      t33_r <= dprod(in_qz, in_qz);
      t01_r <= dprod(in_qw, in_qx);
      t02_r <= dprod(in_qw, in_qy);
      t03_r <= dprod(in_qw, in_qz);
      t12_r <= dprod(in_qx, in_qy);
      t13_r <= dprod(in_qx, in_qz);
      t23_r <= dprod(in_qy, in_qz);
    end
  end

  // Stage B
  logic signed [MW-1:0]   m_nxt [9];
  logic signed [MW-1:0]   s_d;
  logic signed [QW-1:0]   s_nxt;
  logic                   vb_r;
  logic [SLOT_W-1:0]      slot_b_r;
  logic signed [AW-1:0]   acc_b_r [3];
  logic signed [MW-1:0]   m_b_r [9];
  logic signed [QW-1:0]   s_b_r;

  always_comb begin
    m_nxt[0] = Q_ONE_M - MW'(t22_r) - MW'(t33_r);
    m_nxt[1] = MW'(t12_r) - MW'(t03_r);
    m_nxt[2] = MW'(t13_r) + MW'(t02_r);
    m_nxt[3] = MW'(t12_r) + MW'(t03_r);
    m_nxt[4] = Q_ONE_M - MW'(t11_r) - MW'(t33_r);
    m_nxt[5] = MW'(t23_r) - MW'(t01_r);
    m_nxt[6] = MW'(t13_r) - MW'(t02_r);
    m_nxt[7] = MW'(t23_r) + MW'(t01_r);
    m_nxt[8] = Q_ONE_M - MW'(t11_r) - MW'(t22_r);
    s_d = MW'(t02_r) - MW'(t13_r);
    if (s_d > Q_ONE_M) begin
      s_nxt = Q_ONE_M[QW-1:0];
    end else if (s_d < -Q_ONE_M) begin
      s_nxt = -Q_ONE_M[QW-1:0];
    end else begin
      s_nxt = s_d[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot_b_r <= slot_a_r;
      acc_b_r  <= acc_a_r;
      m_b_r    <= m_nxt;
      s_b_r    <= s_nxt;
    end
  end

  // Stage C
  logic signed [2*QW-1:0] ss;
  logic signed [31:0]     bm [3];
  logic                   vc_r;
  logic [SLOT_W-1:0]      slot_c_r;
  logic signed [PW-1:0]   p_c_r [9];
  logic [SQ_NW-1:0]       n_c_r;
  logic signed [QW-1:0]   s_c_r;
  logic signed [MW-1:0]   ang_c_r [4];
  logic signed [AW-1:0]   body_c_r [3];

  always_comb begin
    ss = s_b_r * s_b_r;
    for (int k = 0; k < 3; k++) begin
      bm[k] = 32'(acc_b_r[k]) * 32'sd9800 + 32'sd8192;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot_c_r <= slot_b_r;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_c_r[3*r+c] <= PW'(m_b_r[3*r+c]) * PW'(acc_b_r[c]);
        end
        body_c_r[r] <= bm[r][29:14];
      end
      n_c_r      <= (SQ_NW'(1) << 60) - ss[SQ_NW-1:0];
      s_c_r      <= s_b_r;
      ang_c_r[0] <= m_b_r[8];
      ang_c_r[1] <= m_b_r[7];
      ang_c_r[2] <= m_b_r[0];
      ang_c_r[3] <= m_b_r[3];
    end
  end

  // Stage D
  logic signed [SW-1:0]   w_sum [3];
  logic                   vd_r;
  logic [SLOT_W-1:0]      slot_d_r;
  logic signed [CLW-1:0]  w_d_r [3];
  logic [SQ_NW-1:0]       n_d_r;
  logic signed [QW-1:0]   s_d_r;
  logic signed [MW-1:0]   ang_d_r [4];
  logic signed [AW-1:0]   body_d_r [3];

  always_comb begin
    w_sum[0] = -(SW'(p_c_r[0]) + SW'(p_c_r[1]) + SW'(p_c_r[2]));
    w_sum[1] = -(SW'(p_c_r[3]) + SW'(p_c_r[4]) + SW'(p_c_r[5]));
    w_sum[2] = SW'({gravity, 30'b0}) - SW'(p_c_r[6]) - SW'(p_c_r[7]) - SW'(p_c_r[8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (w_sum[k] > W_LIM) begin
          w_d_r[k] <= W_LIM[CLW-1:0];
        end else if (w_sum[k] < -W_LIM) begin
          w_d_r[k] <= -W_LIM[CLW-1:0];
        end else begin
          w_d_r[k] <= w_sum[k][CLW-1:0];
        end
      end
      slot_d_r <= slot_c_r;
      n_d_r    <= n_c_r;
      s_d_r    <= s_c_r;
      ang_d_r  <= ang_c_r;
      body_d_r <= body_c_r;
    end
  end

  // Stage E
  logic        ve_r;
  side_t       side_e_r;
  logic [SQ_NW-1:0] n_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_e_r.slot    <= slot_d_r;
      side_e_r.roll_x  <= ang_d_r[0];
      side_e_r.roll_y  <= ang_d_r[1];
      side_e_r.yaw_x   <= ang_d_r[2];
      side_e_r.yaw_y   <= ang_d_r[3];
      side_e_r.pitch_s <= s_d_r;
      side_e_r.body_x  <= body_d_r[0];
      side_e_r.body_y  <= body_d_r[1];
      side_e_r.body_z  <= body_d_r[2];
      side_e_r.world_x <= wscale(w_d_r[0]);
      side_e_r.world_y <= wscale(w_d_r[1]);
      side_e_r.world_z <= wscale(w_d_r[2]);
      n_e_r            <= n_d_r;
    end
  end

  assign out_valid = ve_r;
  assign out_side  = side_e_r;
  assign out_n     = n_e_r;

endmodule

### hw/rtl/qew_sqrt.sv
// Pipelined integer square root, one result bit per stage, for the pitch
// cosine. Carries the side-band beat alongside. Uses qew_pkg.
module qew_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  qew_pkg::side_t             in_side,
  input  logic [qew_pkg::SQ_NW-1:0]  in_n,
  output logic                       out_valid,
  output qew_pkg::side_t             out_side,
  output logic [qew_pkg::SQ_RW-1:0]  out_root
);
  import qew_pkg::*;

  logic             v_r    [SQ_STEPS];
  logic [SQ_W-1:0]  rem_r  [SQ_STEPS];
  logic [SQ_W-1:0]  root_r [SQ_STEPS];
  side_t            side_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic            vi;
    logic [SQ_W-1:0] rem_i;
    logic [SQ_W-1:0] root_i;
    logic [SQ_W-1:0] bit_k;
    logic [SQ_W-1:0] trial;
    side_t           side_i;

    if (k == 0) begin : g_first
      assign vi     = in_valid;
      assign rem_i  = SQ_W'(in_n);
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vi     = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign bit_k = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
    assign trial = root_i + bit_k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_i;
        if (rem_i >= trial) begin
          rem_r[k]  <= rem_i - trial;
          root_r[k] <= (root_i >> 1) + bit_k;
        end else begin
          rem_r[k]  <= rem_i;
          root_r[k] <= root_i >> 1;
        end
      end
    end
  end

  assign out_valid = v_r[SQ_STEPS-1];
  assign out_side  = side_r[SQ_STEPS-1];
  assign out_root  = root_r[SQ_STEPS-1][SQ_RW-1:0];

endmodule

### hw/rtl/qew_cordic.sv
// Three-lane vectoring CORDIC for roll, pitch and yaw: one quadrant-fold stage,
// then one stage per micro-rotation. Uses qew_pkg.
module qew_cordic #(
  parameter int STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  qew_pkg::side_t                 in_side,
  input  logic [qew_pkg::SQ_RW-1:0]      in_c,
  output logic                           out_valid,
  output qew_pkg::side_t                 out_side,
  output logic [2:0][qew_pkg::CZW-1:0]   out_z,
  output logic [2:0]                     out_zero
);
  import qew_pkg::*;

  localparam logic signed [CZW-1:0] Z_QUAD = CZW'(90 * 65536);

  logic signed [CXW-1:0] x0 [3];
  logic signed [CXW-1:0] y0 [3];

  logic                  v_r    [STEPS+1];
  side_t                 side_r [STEPS+1];
  logic signed [CXW-1:0] x_r    [STEPS+1][3];
  logic signed [CXW-1:0] y_r    [STEPS+1][3];
  logic signed [CZW-1:0] z_r    [STEPS+1][3];
  logic [2:0]            zero_r [STEPS+1];

  always_comb begin
    x0[CH_ROLL]  = CXW'(in_side.roll_x);
    y0[CH_ROLL]  = CXW'(in_side.roll_y);
    x0[CH_PITCH] = CXW'($signed({1'b0, in_c}));
    y0[CH_PITCH] = CXW'(in_side.pitch_s);
    x0[CH_YAW]   = CXW'(in_side.yaw_x);
    y0[CH_YAW]   = CXW'(in_side.yaw_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int j = 0; j < 3; j++) begin
        zero_r[0][j] <= (x0[j] == '0) && (y0[j] == '0);
        if (x0[j] < 0) begin
          if (y0[j] >= 0) begin
            x_r[0][j] <= y0[j];
            y_r[0][j] <= -x0[j];
            z_r[0][j] <= Z_QUAD;
          end else begin
            x_r[0][j] <= -y0[j];
            y_r[0][j] <= x0[j];
            z_r[0][j] <= -Z_QUAD;
          end
        end else begin
          x_r[0][j] <= x0[j];
          y_r[0][j] <= y0[j];
          z_r[0][j] <= '0;
        end
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [CZW-1:0] ANG = atan_deg(i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i+1] <= side_r[i];
        zero_r[i+1] <= zero_r[i];
        for (int j = 0; j < 3; j++) begin
          if (y_r[i][j] > 0) begin
            x_r[i+1][j] <= x_r[i][j] + (y_r[i][j] >>> i);
            y_r[i+1][j] <= y_r[i][j] - (x_r[i][j] >>> i);
            z_r[i+1][j] <= z_r[i][j] + ANG;
          end else begin
            x_r[i+1][j] <= x_r[i][j] - (y_r[i][j] >>> i);
            y_r[i+1][j] <= y_r[i][j] + (x_r[i][j] >>> i);
            z_r[i+1][j] <= z_r[i][j] - ANG;
          end
        end
      end
    end
  end

  assign out_valid = v_r[STEPS];
  assign out_side  = side_r[STEPS];
  assign out_zero  = zero_r[STEPS];
  assign out_z[0]  = z_r[STEPS][0];
  assign out_z[1]  = z_r[STEPS][1];
  assign out_z[2]  = z_r[STEPS][2];

endmodule

### hw/rtl/quaternion_to_euler_world_accel.sv
// Quaternion to roll/pitch/yaw plus body and world acceleration, top level.
// The pipeline has five front stages, 31 square-root stages, CORDIC_STEPS + 1
// CORDIC stages and the output register.
// Throughput is one beat per cycle; a held output beat stalls every stage.
// Synchronous active-low reset clears all valid bits and sets the gravity
// register to 16384. Depends on qew_pkg, qew_if, qew_front, qew_sqrt, qew_cordic.
module quaternion_to_euler_world_accel #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  qew_in_if.sink           in_beat,
  qew_out_if.source        out_beat,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data
);
  import qew_pkg::*;

  localparam logic signed [CZW-1:0] ROLL_LIM  = CZW'(46080);
  localparam logic signed [CZW-1:0] PITCH_LIM = CZW'(23040);

  logic [AW-1:0] grav_r;
  logic          en;
  logic          out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= AW'(16384);
    end else if (cfg_wr_en) begin
      grav_r <= cfg_wr_data;
    end
  end

  assign en            = !out_valid_r || out_beat.ready;
  assign in_beat.ready = en && rst_n;

  logic             f_valid;
  side_t            f_side;
  logic [SQ_NW-1:0] f_n;

  qew_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_beat.valid),
    .in_slot  (in_beat.sample_slot),
    .in_qw    (in_beat.quat_w),
    .in_qx    (in_beat.quat_x),
    .in_qy    (in_beat.quat_y),
    .in_qz    (in_beat.quat_z),
    .in_ax    (in_beat.acc_raw_x),
    .in_ay    (in_beat.acc_raw_y),
    .in_az    (in_beat.acc_raw_z),
    .gravity  (grav_r),
    .out_valid(f_valid),
    .out_side (f_side),
    .out_n    (f_n)
  );

  logic             s_valid;
  side_t            s_side;
  logic [SQ_RW-1:0] s_root;

  qew_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (f_valid),
    .in_side  (f_side),
    .in_n     (f_n),
    .out_valid(s_valid),
    .out_side (s_side),
    .out_root (s_root)
  );

  logic                  c_valid;
  side_t                 c_side;
  logic [2:0][CZW-1:0]   c_z;
  logic [2:0]            c_zero;

  qew_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s_valid),
    .in_side  (s_side),
    .in_c     (s_root),
    .out_valid(c_valid),
    .out_side (c_side),
    .out_z    (c_z),
    .out_zero (c_zero)
  );

  logic signed [CZW-1:0] ang [3];
  logic signed [CZW-1:0] lim [3];
  logic signed [CZW-1:0] ang_cl [3];

  always_comb begin
    lim[CH_ROLL]  = ROLL_LIM;
    lim[CH_PITCH] = PITCH_LIM;
    lim[CH_YAW]   = ROLL_LIM;
    for (int j = 0; j < 3; j++) begin
      ang[j] = ($signed(c_z[j]) + CZW'(128)) >>> 8;
      if (c_zero[j]) begin
        ang_cl[j] = '0;
      end else if (ang[j] > lim[j]) begin
        ang_cl[j] = lim[j];
      end else if (ang[j] < -lim[j]) begin
        ang_cl[j] = -lim[j];
      end else begin
        ang_cl[j] = ang[j];
      end
    end
  end

  logic [SLOT_W-1:0]         slot_r;
  logic signed [ROLL_W-1:0]  roll_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic signed [ROLL_W-1:0]  yaw_r;
  logic signed [AW-1:0]      body_x_r, body_y_r, body_z_r;
  logic signed [WACC_W-1:0]  world_x_r, world_y_r, world_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot_r    <= c_side.slot;
      roll_r    <= ang_cl[CH_ROLL][ROLL_W-1:0];
      pitch_r   <= ang_cl[CH_PITCH][PITCH_W-1:0];
      yaw_r     <= ang_cl[CH_YAW][ROLL_W-1:0];
      body_x_r  <= c_side.body_x;
      body_y_r  <= c_side.body_y;
      body_z_r  <= c_side.body_z;
      world_x_r <= c_side.world_x;
      world_y_r <= c_side.world_y;
      world_z_r <= c_side.world_z;
    end
  end

  assign out_beat.valid       = out_valid_r;
  assign out_beat.slot_out    = slot_r;
  assign out_beat.roll_angle  = roll_r;
  assign out_beat.pitch_angle = pitch_r;
  assign out_beat.yaw_angle   = yaw_r;
  assign out_beat.body_acc_x  = body_x_r;
  assign out_beat.body_acc_y  = body_y_r;
  assign out_beat.body_acc_z  = body_z_r;
  assign out_beat.world_acc_x = world_x_r;
  assign out_beat.world_acc_y = world_y_r;
  assign out_beat.world_acc_z = world_z_r;

endmodule

### verif/testbench.sv
// Self-checking testbench for the quaternion to Euler angle and world acceleration block.
// Drives random and directed samples through valid/ready channels and checks each result.
// Depends on qew_pkg, qew_if and quaternion_to_euler_world_accel.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qew_pkg::*;

  localparam int NUM_RANDOM  = 1650;
  localparam int LATENCY     = 54;
  localparam longint QONE    = 64'sd1 << 30;

  typedef struct {
    logic [SLOT_W-1:0]        slot;
    logic signed [QW-1:0]     qw, qx, qy, qz;
    logic signed [AW-1:0]     ax, ay, az;
  } sample_t;

  typedef struct {
    logic [SLOT_W-1:0]          slot;
    logic signed [ROLL_W-1:0]   roll;
    logic signed [PITCH_W-1:0]  pitch;
    logic signed [ROLL_W-1:0]   yaw;
    logic signed [AW-1:0]       bx, by, bz;
    logic signed [WACC_W-1:0]   wx, wy, wz;
  } attitude_t;

  class attitude_scoreboard;
    attitude_t pending[$];
    logic [15:0] gravity;
    int mismatches;
    longint atan_lut[16];

    function new();
      gravity = 16'd16384;
      mismatches = 0;
      atan_lut = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115};
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint dbl(longint a, longint b);
      return (a * b) >>> 29;
    endfunction

    function longint angle_of(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 90 * 65536;
        end else begin
          t = x; x = -y; y = t; z = -90 * 65536;
        end
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += atan_lut[i];
        end else begin
          x -= dx; y += dy; z -= atan_lut[i];
        end
      end
      return (z + 128) >>> 8;
    endfunction

    function longint unsigned root_of(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function longint to_world(longint s);
      s = clip(s, -(64'sd1 << 48), 64'sd1 << 48);
      return clip((s * 9800 + (64'sd1 << 43)) >>> 44, -65535, 65535);
    endfunction

    function void note(sample_t smp);
      longint w, x, y, z, ax, ay, az, t11, t22, t33, t01, t02, t03, t12, t13, t23;
      longint s, c, wx, wy, wz;
      attitude_t r;
      w = longint'(smp.qw); x = longint'(smp.qx);
      y = longint'(smp.qy); z = longint'(smp.qz);
      ax = longint'(smp.ax); ay = longint'(smp.ay); az = longint'(smp.az);
      t11 = dbl(x, x); t22 = dbl(y, y); t33 = dbl(z, z);
      t01 = dbl(w, x); t02 = dbl(w, y); t03 = dbl(w, z);
      t12 = dbl(x, y); t13 = dbl(x, z); t23 = dbl(y, z);
      r.slot = smp.slot;
      r.roll = ROLL_W'(clip(angle_of(t01 + t23, QONE - t11 - t22), -46080, 46080));
      r.yaw = ROLL_W'(clip(angle_of(t12 + t03, QONE - t33 - t22), -46080, 46080));
      s = clip(t02 - t13, -QONE, QONE);
      c = longint'(root_of((64'd1 << 60) - longint'(s * s)));
      r.pitch = PITCH_W'(clip(angle_of(s, c), -23040, 23040));
      r.bx = AW'((ax * 9800 + 8192) >>> 14);
      r.by = AW'((ay * 9800 + 8192) >>> 14);
      r.bz = AW'((az * 9800 + 8192) >>> 14);
      wx = -(QONE - t22 - t33) * ax - (t12 - t03) * ay - (t13 + t02) * az;
      wy = -(t12 + t03) * ax - (QONE - t11 - t33) * ay - (t23 - t01) * az;
      wz = longint'(gravity) * QONE - (t13 - t02) * ax - (t23 + t01) * ay
           - (QONE - t11 - t22) * az;
      r.wx = WACC_W'(to_world(wx));
      r.wy = WACC_W'(to_world(wy));
      r.wz = WACC_W'(to_world(wz));
      pending.push_back(r);
    endfunction

    function void check(attitude_t act);
      attitude_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat, slot %0d", act.slot);
        return;
      end
      e = pending.pop_front();
      if (e != act) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch exp slot=%0d r=%0d p=%0d y=%0d b=%0d,%0d,%0d w=%0d,%0d,%0d",
                   e.slot, e.roll, e.pitch, e.yaw, e.bx, e.by, e.bz, e.wx, e.wy, e.wz);
          $display("         act slot=%0d r=%0d p=%0d y=%0d b=%0d,%0d,%0d w=%0d,%0d,%0d",
                   act.slot, act.roll, act.pitch, act.yaw, act.bx, act.by, act.bz,
                   act.wx, act.wy, act.wz);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;
  qew_in_if in_beat();
  qew_out_if out_beat();
  attitude_scoreboard sb;
  int results_seen;

  quaternion_to_euler_world_accel uut (
    .clk(clk), .rst_n(rst_n), .in_beat(in_beat.sink), .out_beat(out_beat.source),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stall pattern, calm stretches, and one long hold-off.
  initial begin
    int hold, mode, left;
    bit held_once;
    hold = 0; mode = 0; left = 0; held_once = 0;
    out_beat.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && results_seen >= 200) begin
        held_once = 1;
        hold = 400;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 150);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_beat.ready <= 1'b0;
      end else if (mode == 0) out_beat.ready <= 1'b1;
      else if (mode == 1) out_beat.ready <= ($urandom_range(0, 3) != 0);
      else out_beat.ready <= ($urandom_range(0, 1) != 0);
    end
  end

  always @(posedge clk) begin
    attitude_t a;
    if (rst_n && out_beat.valid && out_beat.ready) begin
      a.slot = out_beat.slot_out;
      a.roll = out_beat.roll_angle;
      a.pitch = out_beat.pitch_angle;
      a.yaw = out_beat.yaw_angle;
      a.bx = out_beat.body_acc_x;
      a.by = out_beat.body_acc_y;
      a.bz = out_beat.body_acc_z;
      a.wx = out_beat.world_acc_x;
      a.wy = out_beat.world_acc_y;
      a.wz = out_beat.world_acc_z;
      sb.check(a);
      results_seen++;
    end
  end

  int burst_left;

  task automatic send_sample(sample_t s);
    if (burst_left == 0) begin
      in_beat.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_beat.valid <= 1'b1;
    in_beat.sample_slot <= s.slot;
    in_beat.quat_w <= s.qw;
    in_beat.quat_x <= s.qx;
    in_beat.quat_y <= s.qy;
    in_beat.quat_z <= s.qz;
    in_beat.acc_raw_x <= s.ax;
    in_beat.acc_raw_y <= s.ay;
    in_beat.acc_raw_z <= s.az;
    @(posedge clk);
    while (!in_beat.ready) @(posedge clk);
    sb.note(s);
  endtask

  task automatic write_gravity(logic [15:0] g);
    in_beat.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= g;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.gravity = g;
  endtask

  function automatic sample_t make_sample(int kind);
    sample_t s;
    real c[4];
    real n, k;
    s.slot = SLOT_W'($urandom_range(0, 15));
    s.ax = AW'($urandom); s.ay = AW'($urandom); s.az = AW'($urandom);
    if (kind < 80) begin
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
        c[i] = real'($urandom_range(0, 2000000)) - 1000000.0;
        n += c[i] * c[i];
      end
      if (n == 0.0) begin
        c[0] = 1.0; n = 1.0;
      end
      k = (kind < 70) ? 1073741824.0 : 1073741824.0 * real'($urandom_range(1, 1000)) / 1000.0;
      n = $sqrt(n);
      s.qw = $rtoi(c[0] * k / n);
      s.qx = $rtoi(c[1] * k / n);
      s.qy = $rtoi(c[2] * k / n);
      s.qz = $rtoi(c[3] * k / n);
    end else begin
      s.qw = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      s.qx = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      s.qy = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      s.qz = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    end
    return s;
  endfunction

  function automatic sample_t fixed_sample(logic [3:0] sl, int w, int x, int y, int z,
                                           int ax, int ay, int az);
    sample_t s;
    s.slot = sl; s.qw = w; s.qx = x; s.qy = y; s.qz = z;
    s.ax = AW'(ax); s.ay = AW'(ay); s.az = AW'(az);
    return s;
  endfunction

  initial begin
    int one, h;
    logic [15:0] grav_list[4];
    sb = new();
    results_seen = 0;
    burst_left = 0;
    one = 1 << 30;
    h = 759250125;
    grav_list = '{16'd0, 16'd65535, 16'd9000, 16'd16384};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_beat.valid = 1'b0;
    in_beat.sample_slot = '0;
    in_beat.quat_w = '0; in_beat.quat_x = '0; in_beat.quat_y = '0; in_beat.quat_z = '0;
    in_beat.acc_raw_x = '0; in_beat.acc_raw_y = '0; in_beat.acc_raw_z = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(fixed_sample(0, one, 0, 0, 0, 0, 0, 16384));
    send_sample(fixed_sample(15, 0, 0, 0, 0, 32767, -32768, 0));
    send_sample(fixed_sample(1, -one, 0, 0, 0, -32768, 32767, -32768));
    send_sample(fixed_sample(2, 0, one, 0, 0, 1, -1, 32767));
    send_sample(fixed_sample(3, 0, 0, one, 0, 32767, 32767, 32767));
    send_sample(fixed_sample(4, 0, 0, 0, one, -32768, -32768, -32768));
    send_sample(fixed_sample(5, 0, -one, 0, 0, 100, 200, 300));
    send_sample(fixed_sample(6, 0, 0, -one, 0, -1, 0, 1));
    send_sample(fixed_sample(7, 0, 0, 0, -one, 8192, -8192, 0));
    send_sample(fixed_sample(8, h, 0, h, 0, 0, 0, 16384));
    send_sample(fixed_sample(9, h, 0, -h, 0, 0, 16384, 0));
    send_sample(fixed_sample(10, one, 0, one, 0, 1000, -1000, 5000));
    send_sample(fixed_sample(11, one, -one, -one, one, 32767, 32767, -32768));
    send_sample(fixed_sample(12, one, one, one, one, -32768, -32768, -32768));
    send_sample(fixed_sample(13, -one, -one, -one, -one, 32767, 32767, 32767));
    send_sample(fixed_sample(14, h, h, 0, 0, 0, 0, 0));
    send_sample(fixed_sample(3, h, 0, 0, h, -5, 7, -9));
    send_sample(fixed_sample(6, -h, h, 0, 0, 12345, -23456, 30000));
    send_sample(fixed_sample(9, 1, 1, 0, 0, 0, 0, 0));

    for (int p = 0; p < 4; p++) begin
      write_gravity(grav_list[p]);
      for (int i = 0; i < NUM_RANDOM / 4; i++) send_sample(make_sample($urandom_range(0, 99)));
    end

    in_beat.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
